FILE: hdl/pse_pkg.sv
// Shared constants and types of the postfix stack evaluator.
package pse_pkg;

   localparam int DATA_W      = 32;
   localparam int STACK_DEPTH = 64;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 3'd0,
      KIND_ADD    = 3'd1,
      KIND_SUB    = 3'd2,
      KIND_MUL    = 3'd3,
      KIND_DIV    = 3'd4,
      KIND_FINISH = 3'd5
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_DIV_ZERO  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_move_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_COMMIT
   } state_type;

endpackage

FILE: hdl/pse_req_if.sv
// Token channel: valid/ready handshake with token kind and operand.
interface pse_req_if import pse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        req_type;
   logic signed [DATA_W-1:0] operand;

   modport source (output valid, req_type, operand, input ready);
   modport sink (input valid, req_type, operand, output ready);
endinterface

FILE: hdl/pse_rsp_if.sv
// Result channel: valid/ready handshake with top value, count and status.
interface pse_rsp_if import pse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic [COUNT_W-1:0]       stack_count;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, top_value, stack_count, status, input ready);
   modport sink (input valid, top_value, stack_count, status, output ready);
endinterface

FILE: hdl/pse_cell.sv
// One stack cell: holds an entry, or takes it from the neighbor above or below.
module pse_cell import pse_pkg::*; (
   input  logic                clock,
   input  cell_move_type       move,
   input  logic [DATA_W-1:0]   prev_data,
   input  logic [DATA_W-1:0]   next_data,
   output logic [DATA_W-1:0]   data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      unique case (move)
         CELL_HOLD:      data_in = data_ff;
         CELL_FROM_PREV: data_in = prev_data;
         CELL_FROM_NEXT: data_in = next_data;
         default:        data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: hdl/pse_divider.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
module pse_divider import pse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DATA_W);
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

FILE: hdl/postfix_stack_evaluator.sv
// Postfix (RPN) integer evaluator: a 64-entry stack built as a chain of shifting
// cells, with the top entry in the first cell. A token is taken whenever the
// evaluator is idle, even while the previous result still waits in the output
// register. Push, add, subtract, finish and unused kinds go from idle to the
// commit state, multiply passes through the multiply state first, and divide
// waits in the divide state for the divider, which produces one quotient bit per
// cycle. The commit state loads the result into the output register once that
// register is free, and then returns to idle. Each token gives exactly one
// result: the new top (or the popped value on finish), the entry count and a
// status of ok, underflow (an empty pop reads as -1), overflow (push to a full
// stack is dropped) or divide by zero (pushes 0).
module postfix_stack_evaluator import pse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pse_req_if.sink     req,
   pse_rsp_if.source   rsp
);

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [KIND_W-1:0]    kind_ff;
   logic [DATA_W-1:0]    operand_ff;
   logic [DATA_W-1:0]    a_ff;
   logic [DATA_W-1:0]    b_ff;
   logic [DATA_W-1:0]    result_ff;
   logic                 div_start_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_top_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   status_type           rsp_status_ff;

   logic [DATA_W-1:0]    cell_data [STACK_DEPTH];
   cell_move_type        head_move;
   cell_move_type        body_move;
   logic [DATA_W-1:0]    load_value;

   logic                 accept;
   logic                 out_free;
   logic                 commit;
   logic                 empty;
   logic                 under2;
   logic                 full;
   logic [DATA_W-1:0]    product;
   logic                 div_done;
   logic [DATA_W-1:0]    div_quotient;

   logic [DATA_W-1:0]    commit_top;
   logic [COUNT_W-1:0]   commit_count;
   status_type           commit_status;
   cell_move_type        commit_head;
   cell_move_type        commit_body;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] prev_data;
      logic [DATA_W-1:0] next_data;
      cell_move_type     move;
      if (i == 0) begin : g_head
         assign prev_data = load_value;
         assign move      = head_move;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
         assign move      = body_move;
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign next_data = '0;
      end else begin : g_link
         assign next_data = cell_data[i+1];
      end
      pse_cell u_cell (
         .clock     (clock),
         .move      (move),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   pse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign empty    = (count_ff == '0);
   assign under2   = (count_ff < COUNT_W'(2));
   assign full     = (count_ff == COUNT_W'(STACK_DEPTH));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign accept   = req.valid && req.ready;
   assign product  = a_ff * b_ff;

   always_comb begin
      commit_head   = CELL_HOLD;
      commit_body   = CELL_HOLD;
      commit_count  = count_ff;
      commit_status = STATUS_OK;
      commit_top    = empty ? '0 : cell_data[0];
      load_value    = operand_ff;
      unique case (kind_ff)
         KIND_PUSH: begin
            if (full) begin
               commit_status = STATUS_OVERFLOW;
            end else begin
               commit_head  = CELL_FROM_PREV;
               commit_body  = CELL_FROM_PREV;
               commit_count = count_ff + 1'b1;
               commit_top   = operand_ff;
            end
         end
         KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
            if (kind_ff == KIND_ADD) begin
               load_value = a_ff + b_ff;
            end else if (kind_ff == KIND_SUB) begin
               load_value = a_ff - b_ff;
            end else if (kind_ff == KIND_DIV && b_ff == '0) begin
               load_value    = '0;
               commit_status = STATUS_DIV_ZERO;
            end else begin
               load_value = result_ff;
            end
            if (under2) begin
               commit_status = STATUS_UNDERFLOW;
               commit_count  = COUNT_W'(1);
            end else begin
               commit_count = count_ff - 1'b1;
            end
            commit_head = CELL_FROM_PREV;
            commit_body = CELL_FROM_NEXT;
            commit_top  = load_value;
         end
         KIND_FINISH: begin
            commit_top = b_ff;
            if (empty) begin
               commit_status = STATUS_UNDERFLOW;
            end else begin
               commit_head  = CELL_FROM_NEXT;
               commit_body  = CELL_FROM_NEXT;
               commit_count = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      req.ready    = 1'b0;
      commit       = 1'b0;
      head_move    = CELL_HOLD;
      body_move    = CELL_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.req_type == KIND_MUL) begin
                  state_in = ST_MUL;
               end else if (req.req_type == KIND_DIV) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_COMMIT;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               commit    = 1'b1;
               head_move = commit_head;
               body_move = commit_body;
               count_in  = commit_count;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= accept && (req.req_type == KIND_DIV);
      end
      if (accept) begin
         kind_ff    <= req.req_type;
         operand_ff <= req.operand;
         b_ff       <= empty ? '1 : cell_data[0];
         a_ff       <= under2 ? '1 : cell_data[1];
      end
      if (state_ff == ST_MUL) begin
         result_ff <= product;
      end else if (state_ff == ST_DIV && div_done) begin
         result_ff <= div_quotient;
      end
      if (commit) begin
         rsp_top_ff    <= commit_top;
         rsp_count_ff  <= commit_count;
         rsp_status_ff <= commit_status;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.top_value   = rsp_top_ff;
   assign rsp.stack_count = rsp_count_ff;
   assign rsp.status      = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result appeared without a commit");

   assert property (@(posedge clock) disable iff (reset)
      commit && (kind_ff == KIND_ADD || kind_ff == KIND_SUB ||
                 kind_ff == KIND_MUL || kind_ff == KIND_DIV)
      |=> count_ff != '0)
      else $error("operator left the stack empty");

endmodule
